@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked check in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/c8x_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8x_pkg
// Operation codes, flag positions and reset values for the 6502 executor.
// ----------------------------------------------------------------------------
package c8x_pkg;

    localparam int STACK_DEPTH_DEF = 256;

    typedef enum logic [5:0] {
        OP_INVALID = 6'd0,
        OP_ADC = 6'd1, OP_AND = 6'd2, OP_ASL_M = 6'd3, OP_ASL_A = 6'd4,
        OP_BCC = 6'd5, OP_BCS = 6'd6, OP_BEQ = 6'd7, OP_BIT = 6'd8,
        OP_BMI = 6'd9, OP_BNE = 6'd10, OP_BPL = 6'd11, OP_BRK = 6'd12,
        OP_BVC = 6'd13, OP_BVS = 6'd14, OP_CLC = 6'd15, OP_CLD = 6'd16,
        OP_CLI = 6'd17, OP_CLV = 6'd18, OP_CMP = 6'd19, OP_CPX = 6'd20,
        OP_CPY = 6'd21, OP_DEC = 6'd22, OP_DEX = 6'd23, OP_DEY = 6'd24,
        OP_EOR = 6'd25, OP_INC = 6'd26, OP_INX = 6'd27, OP_INY = 6'd28,
        OP_JMP = 6'd29, OP_JSR = 6'd30, OP_LDA = 6'd31, OP_LDX = 6'd32,
        OP_LDY = 6'd33, OP_LSR_M = 6'd34, OP_LSR_A = 6'd35, OP_NOP = 6'd36,
        OP_ORA = 6'd37, OP_PHA = 6'd38, OP_PHP = 6'd39, OP_PLA = 6'd40,
        OP_PLP = 6'd41, OP_ROL_M = 6'd42, OP_ROL_A = 6'd43, OP_ROR_M = 6'd44,
        OP_ROR_A = 6'd45, OP_RTI = 6'd46, OP_RTS = 6'd47, OP_SBC = 6'd48,
        OP_SEC = 6'd49, OP_SED = 6'd50, OP_SEI = 6'd51, OP_STA = 6'd52,
        OP_STX = 6'd53, OP_STY = 6'd54, OP_TAX = 6'd55, OP_TAY = 6'd56,
        OP_TSX = 6'd57, OP_TXA = 6'd58, OP_TXS = 6'd59, OP_TYA = 6'd60
    } op_t;

    typedef enum logic [0:0] {
        REG_IRQ_VECTOR = 1'b0,
        REG_DECIMAL_ENABLE = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_RUN, ST_CLEAR, ST_PUSH, ST_PULL, ST_PULL_WAIT, ST_OUT
    } state_t;

    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_B = 4;
    localparam int FL_U = 5;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    localparam logic [7:0] SP_RESET = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

endpackage

@@ hdl/cpu_8bit_instruction_execute_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_8bit_instruction_execute_top
// Executes one decoded 6502 instruction per word with a page-one stack RAM.
// ----------------------------------------------------------------------------
// Most instructions finish in ST_RUN and may follow each other back to back
// while the output is not stalled. Every stack byte goes through the single
// port of the stack RAM, which has a registered read, and a stack instruction
// releases its result through ST_OUT after its last stack access (pulls pass
// ST_PULL_WAIT first). PHA and PHP push one byte, JSR two and BRK three; PLA
// and PLP pull one byte, RTS two and RTI three. After reset the stack RAM is
// cleared one entry per cycle, every entry up to STACK_DEPTH - 1, during which
// no word is accepted. The result sits in an output register; a new word is
// taken at the edge where the last result leaves or once it has left.
module cpu_8bit_instruction_execute_top #(
    parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  operation,
    input  logic [7:0]  operand,
    input  logic [15:0] target,
    input  logic [15:0] fall_through_pc,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] next_pc,
    output logic        mem_write,
    output logic [7:0]  write_data,
    output logic [7:0]  acc_out,
    output logic [7:0]  x_out,
    output logic [7:0]  y_out,
    output logic [7:0]  sp_out,
    output logic [7:0]  status_out,
    output logic        halted,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    `include "assert_macros.svh"

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    c8x_pkg::state_t state_reg, state_next;

    logic [7:0]  a_reg, a_next, x_reg, x_next, y_reg, y_next;
    logic [7:0]  sp_reg, sp_next, p_reg, p_next;
    logic        halt_reg, halt_next;
    logic [15:0] vec_reg;
    logic        dec_en_reg;

    // Multi-cycle sequence context.
    c8x_pkg::op_t op_reg, op_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  pull0_reg, pull0_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic [15:0] npc_reg, npc_next;
    logic        mw_reg, mw_next;
    logic [7:0]  wd_reg, wd_next;
    logic        ov_reg, ov_next;

    logic [7:0]  ram [STACK_DEPTH];
    logic [7:0]  rd_q;
    logic        ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]  ram_wd;

    logic        out_free, in_acc;
    c8x_pkg::op_t op_in;

    // Combinational ALU results.
    logic [7:0]  alu_a, alu_x, alu_y, alu_sp, alu_p, alu_wd;
    logic [15:0] alu_pc;
    logic        alu_mw, alu_halt;

    logic [8:0]  bin;
    logic [4:0]  dlo;
    logic [9:0]  dt;
    logic        bcd;
    logic signed [5:0] slo;
    logic signed [9:0] sr;
    logic [8:0]  cmp_d;
    logic [7:0]  cmp_r;
    logic [7:0]  sh;
    logic [15:0] addr16;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = !(state_reg == c8x_pkg::ST_RUN) || !out_free;
    assign in_acc = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign op_in = c8x_pkg::op_t'(operation);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= 16'h0000;
            dec_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                c8x_pkg::REG_IRQ_VECTOR:     vec_reg <= cfg_data;
                c8x_pkg::REG_DECIMAL_ENABLE: dec_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [7:0] p;
        logic [7:0] cv;
        p = p_reg;
        alu_a = a_reg; alu_x = x_reg; alu_y = y_reg; alu_sp = sp_reg;
        alu_pc = fall_through_pc; alu_mw = 1'b0; alu_wd = 8'h00;
        alu_halt = 1'b0;
        bcd = dec_en_reg && p_reg[c8x_pkg::FL_D];
        bin = 9'(a_reg) + 9'(operand) + 9'(p_reg[c8x_pkg::FL_C]);
        dlo = 5'(a_reg[3:0]) + 5'(operand[3:0]) + 5'(p_reg[c8x_pkg::FL_C]);
        if (dlo >= 5'h0A)
            dlo = 5'(((dlo + 5'h06) & 5'h0F) + 5'h10);
        dt = 10'({a_reg[7:4], 4'h0}) + 10'({operand[7:4], 4'h0}) + 10'(dlo);
        slo = 6'sd0;
        sr = 10'sd0;
        cmp_d = 9'd0;
        cmp_r = 8'h00;
        sh = 8'h00;
        cv = 8'h00;
        case (op_in)
            c8x_pkg::OP_ADC:
            begin
                if (!bcd)
                begin
                    p[c8x_pkg::FL_C] = bin[8];
                    p[c8x_pkg::FL_V] = ~(a_reg[7] ^ operand[7]) & (a_reg[7] ^ bin[7]);
                    alu_a = bin[7:0];
                    p[c8x_pkg::FL_Z] = (bin[7:0] == 8'h00);
                    p[c8x_pkg::FL_N] = bin[7];
                end
                else
                begin
                    p[c8x_pkg::FL_Z] = (bin[7:0] == 8'h00);
                    p[c8x_pkg::FL_N] = dt[7];
                    p[c8x_pkg::FL_V] = ~(a_reg[7] ^ operand[7]) & (a_reg[7] ^ dt[7]);
                    if (dt >= 10'h0A0)
                        dt = dt + 10'h060;
                    p[c8x_pkg::FL_C] = (dt >= 10'h100);
                    alu_a = dt[7:0];
                end
            end
            c8x_pkg::OP_SBC:
            begin
                bin = 9'(a_reg) + {1'b0, ~operand} + 9'(p_reg[c8x_pkg::FL_C]);
                p[c8x_pkg::FL_C] = bin[8];
                p[c8x_pkg::FL_V] = (a_reg[7] ^ operand[7]) & (a_reg[7] ^ bin[7]);
                p[c8x_pkg::FL_Z] = (bin[7:0] == 8'h00);
                p[c8x_pkg::FL_N] = bin[7];
                alu_a = bin[7:0];
                if (bcd)
                begin
                    slo = $signed({2'b00, a_reg[3:0]}) - $signed({2'b00, operand[3:0]})
                        + $signed({5'b0, p_reg[c8x_pkg::FL_C]}) - 6'sd1;
                    if (slo < 0)
                        slo = $signed(((slo + 6'sd26) & 6'sh0F)) - 6'sd16;
                    sr = $signed({2'b00, a_reg[7:4], 4'h0})
                        - $signed({2'b00, operand[7:4], 4'h0}) + 10'(slo);
                    if (sr < 0)
                        sr = sr - 10'sd96;
                    alu_a = sr[7:0];
                end
            end
            c8x_pkg::OP_AND, c8x_pkg::OP_EOR, c8x_pkg::OP_ORA, c8x_pkg::OP_LDA,
            c8x_pkg::OP_TXA, c8x_pkg::OP_TYA:
            begin
                case (op_in)
                    c8x_pkg::OP_AND: alu_a = a_reg & operand;
                    c8x_pkg::OP_EOR: alu_a = a_reg ^ operand;
                    c8x_pkg::OP_ORA: alu_a = a_reg | operand;
                    c8x_pkg::OP_LDA: alu_a = operand;
                    c8x_pkg::OP_TXA: alu_a = x_reg;
                    default:         alu_a = y_reg;
                endcase
                p[c8x_pkg::FL_Z] = (alu_a == 8'h00);
                p[c8x_pkg::FL_N] = alu_a[7];
            end
            c8x_pkg::OP_LDX, c8x_pkg::OP_TAX, c8x_pkg::OP_TSX, c8x_pkg::OP_INX,
            c8x_pkg::OP_DEX:
            begin
                case (op_in)
                    c8x_pkg::OP_LDX: alu_x = operand;
                    c8x_pkg::OP_TAX: alu_x = a_reg;
                    c8x_pkg::OP_TSX: alu_x = sp_reg;
                    c8x_pkg::OP_INX: alu_x = x_reg + 8'd1;
                    default:         alu_x = x_reg - 8'd1;
                endcase
                p[c8x_pkg::FL_Z] = (alu_x == 8'h00);
                p[c8x_pkg::FL_N] = alu_x[7];
            end
            c8x_pkg::OP_LDY, c8x_pkg::OP_TAY, c8x_pkg::OP_INY, c8x_pkg::OP_DEY:
            begin
                case (op_in)
                    c8x_pkg::OP_LDY: alu_y = operand;
                    c8x_pkg::OP_TAY: alu_y = a_reg;
                    c8x_pkg::OP_INY: alu_y = y_reg + 8'd1;
                    default:         alu_y = y_reg - 8'd1;
                endcase
                p[c8x_pkg::FL_Z] = (alu_y == 8'h00);
                p[c8x_pkg::FL_N] = alu_y[7];
            end
            c8x_pkg::OP_ASL_M, c8x_pkg::OP_LSR_M, c8x_pkg::OP_ROL_M, c8x_pkg::OP_ROR_M,
            c8x_pkg::OP_ASL_A, c8x_pkg::OP_LSR_A, c8x_pkg::OP_ROL_A, c8x_pkg::OP_ROR_A:
            begin
                if (op_in == c8x_pkg::OP_ASL_M || op_in == c8x_pkg::OP_LSR_M
                    || op_in == c8x_pkg::OP_ROL_M || op_in == c8x_pkg::OP_ROR_M)
                    cv = operand;
                else
                    cv = a_reg;
                case (op_in)
                    c8x_pkg::OP_ASL_M, c8x_pkg::OP_ASL_A:
                    begin
                        sh = {cv[6:0], 1'b0}; p[c8x_pkg::FL_C] = cv[7];
                    end
                    c8x_pkg::OP_ROL_M, c8x_pkg::OP_ROL_A:
                    begin
                        sh = {cv[6:0], p_reg[c8x_pkg::FL_C]}; p[c8x_pkg::FL_C] = cv[7];
                    end
                    c8x_pkg::OP_LSR_M, c8x_pkg::OP_LSR_A:
                    begin
                        sh = {1'b0, cv[7:1]}; p[c8x_pkg::FL_C] = cv[0];
                    end
                    default:
                    begin
                        sh = {p_reg[c8x_pkg::FL_C], cv[7:1]}; p[c8x_pkg::FL_C] = cv[0];
                    end
                endcase
                p[c8x_pkg::FL_Z] = (sh == 8'h00);
                p[c8x_pkg::FL_N] = sh[7];
                if (cv == operand && (op_in == c8x_pkg::OP_ASL_M
                    || op_in == c8x_pkg::OP_LSR_M || op_in == c8x_pkg::OP_ROL_M
                    || op_in == c8x_pkg::OP_ROR_M))
                begin
                    alu_mw = 1'b1; alu_wd = sh;
                end
                else
                    alu_a = sh;
            end
            c8x_pkg::OP_INC, c8x_pkg::OP_DEC:
            begin
                alu_wd = (op_in == c8x_pkg::OP_INC) ? operand + 8'd1 : operand - 8'd1;
                alu_mw = 1'b1;
                p[c8x_pkg::FL_Z] = (alu_wd == 8'h00);
                p[c8x_pkg::FL_N] = alu_wd[7];
            end
            c8x_pkg::OP_CMP, c8x_pkg::OP_CPX, c8x_pkg::OP_CPY:
            begin
                case (op_in)
                    c8x_pkg::OP_CMP: cmp_r = a_reg;
                    c8x_pkg::OP_CPX: cmp_r = x_reg;
                    default:         cmp_r = y_reg;
                endcase
                cmp_d = 9'(cmp_r) - 9'(operand);
                p[c8x_pkg::FL_Z] = (cmp_d[7:0] == 8'h00);
                p[c8x_pkg::FL_N] = cmp_d[7];
                p[c8x_pkg::FL_C] = !cmp_d[8];
            end
            c8x_pkg::OP_BIT:
            begin
                p[c8x_pkg::FL_Z] = ((a_reg & operand) == 8'h00);
                p[c8x_pkg::FL_N] = operand[7];
                p[c8x_pkg::FL_V] = operand[6];
            end
            c8x_pkg::OP_BCC: if (!p_reg[c8x_pkg::FL_C]) alu_pc = target;
            c8x_pkg::OP_BCS: if (p_reg[c8x_pkg::FL_C]) alu_pc = target;
            c8x_pkg::OP_BEQ: if (p_reg[c8x_pkg::FL_Z]) alu_pc = target;
            c8x_pkg::OP_BNE: if (!p_reg[c8x_pkg::FL_Z]) alu_pc = target;
            c8x_pkg::OP_BMI: if (p_reg[c8x_pkg::FL_N]) alu_pc = target;
            c8x_pkg::OP_BPL: if (!p_reg[c8x_pkg::FL_N]) alu_pc = target;
            c8x_pkg::OP_BVC: if (!p_reg[c8x_pkg::FL_V]) alu_pc = target;
            c8x_pkg::OP_BVS: if (p_reg[c8x_pkg::FL_V]) alu_pc = target;
            c8x_pkg::OP_JMP: alu_pc = target;
            c8x_pkg::OP_CLC: p[c8x_pkg::FL_C] = 1'b0;
            c8x_pkg::OP_CLD: p[c8x_pkg::FL_D] = 1'b0;
            c8x_pkg::OP_CLI: p[c8x_pkg::FL_I] = 1'b0;
            c8x_pkg::OP_CLV: p[c8x_pkg::FL_V] = 1'b0;
            c8x_pkg::OP_SEC: p[c8x_pkg::FL_C] = 1'b1;
            c8x_pkg::OP_SED: p[c8x_pkg::FL_D] = 1'b1;
            c8x_pkg::OP_SEI: p[c8x_pkg::FL_I] = 1'b1;
            c8x_pkg::OP_STA: begin alu_mw = 1'b1; alu_wd = a_reg; end
            c8x_pkg::OP_STX: begin alu_mw = 1'b1; alu_wd = x_reg; end
            c8x_pkg::OP_STY: begin alu_mw = 1'b1; alu_wd = y_reg; end
            c8x_pkg::OP_TXS: alu_sp = x_reg;
            c8x_pkg::OP_NOP: ;
            // Stack instructions are finished by the sequencer.
            c8x_pkg::OP_BRK, c8x_pkg::OP_JSR, c8x_pkg::OP_PHA, c8x_pkg::OP_PHP,
            c8x_pkg::OP_PLA, c8x_pkg::OP_PLP, c8x_pkg::OP_RTI, c8x_pkg::OP_RTS: ;
            default: alu_halt = 1'b1;
        endcase
        alu_p = p;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            c8x_pkg::ST_CLEAR:
                if (clr_reg == AW'(STACK_DEPTH - 1))
                    state_next = c8x_pkg::ST_RUN;
            c8x_pkg::ST_RUN:
                if (in_acc && !halt_reg)
                begin
                    case (op_in)
                        c8x_pkg::OP_BRK, c8x_pkg::OP_JSR, c8x_pkg::OP_PHA,
                        c8x_pkg::OP_PHP:
                            state_next = c8x_pkg::ST_PUSH;
                        c8x_pkg::OP_PLA, c8x_pkg::OP_PLP, c8x_pkg::OP_RTI,
                        c8x_pkg::OP_RTS:
                            state_next = c8x_pkg::ST_PULL;
                        default: state_next = c8x_pkg::ST_RUN;
                    endcase
                end
            c8x_pkg::ST_PUSH:
                if (cnt_reg == 2'd0)
                    state_next = c8x_pkg::ST_OUT;
            c8x_pkg::ST_PULL:
                if (cnt_reg == 2'd0)
                    state_next = c8x_pkg::ST_PULL_WAIT;
            c8x_pkg::ST_PULL_WAIT: state_next = c8x_pkg::ST_OUT;
            c8x_pkg::ST_OUT:
                if (out_free)
                    state_next = c8x_pkg::ST_RUN;
            default: state_next = c8x_pkg::ST_RUN;
        endcase
    end

    always_comb
    begin
        a_next = a_reg; x_next = x_reg; y_next = y_reg; sp_next = sp_reg;
        p_next = p_reg; halt_next = halt_reg;
        op_next = op_reg; cnt_next = cnt_reg; pc_next = pc_reg;
        pull0_next = pull0_reg;
        clr_next = clr_reg;
        npc_next = npc_reg; mw_next = mw_reg; wd_next = wd_reg;
        ov_next = ov_reg && out_stall;
        ram_we = 1'b0; ram_re = 1'b0; ram_addr = AW'(sp_reg); ram_wd = 8'h00;
        addr16 = 16'h0000;
        case (state_reg)
            c8x_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1; ram_addr = clr_reg; ram_wd = 8'h00;
                clr_next = clr_reg + AW'(1);
            end
            c8x_pkg::ST_RUN:
                if (in_acc)
                begin
                    op_next = op_in;
                    pc_next = fall_through_pc;
                    if (halt_reg || alu_halt)
                    begin
                        halt_next = 1'b1;
                        npc_next = fall_through_pc; mw_next = 1'b0; wd_next = 8'h00;
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        case (op_in)
                            c8x_pkg::OP_BRK: begin cnt_next = 2'd2; pc_next = fall_through_pc + 16'd1; end
                            c8x_pkg::OP_JSR: begin cnt_next = 2'd1; pc_next = fall_through_pc - 16'd1; end
                            c8x_pkg::OP_RTI: cnt_next = 2'd2;
                            c8x_pkg::OP_RTS: cnt_next = 2'd1;
                            default: cnt_next = 2'd0;
                        endcase
                        if (state_next == c8x_pkg::ST_RUN)
                        begin
                            a_next = alu_a; x_next = alu_x; y_next = alu_y;
                            sp_next = alu_sp; p_next = alu_p;
                            npc_next = alu_pc; mw_next = alu_mw; wd_next = alu_wd;
                            ov_next = 1'b1;
                        end
                        else
                        begin
                            npc_next = (op_in == c8x_pkg::OP_JSR) ? target : fall_through_pc;
                        end
                    end
                end
            c8x_pkg::ST_PUSH:
            begin
                ram_we = 1'b1; ram_addr = AW'(sp_reg);
                case (op_reg)
                    c8x_pkg::OP_BRK, c8x_pkg::OP_JSR:
                        case (cnt_reg)
                            2'd2:    ram_wd = pc_reg[15:8];
                            2'd1:    ram_wd = (op_reg == c8x_pkg::OP_JSR) ? pc_reg[15:8]
                                                                           : pc_reg[7:0];
                            default: ram_wd = (op_reg == c8x_pkg::OP_JSR) ? pc_reg[7:0]
                                                                           : (p_reg | 8'h30);
                        endcase
                    c8x_pkg::OP_PHA: ram_wd = a_reg;
                    default:         ram_wd = p_reg | 8'h30;
                endcase
                sp_next = sp_reg - 8'd1;
                cnt_next = cnt_reg - 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    mw_next = 1'b0; wd_next = 8'h00;
                    if (op_reg == c8x_pkg::OP_BRK)
                    begin
                        p_next[c8x_pkg::FL_I] = 1'b1;
                        npc_next = vec_reg;
                    end
                end
            end
            c8x_pkg::ST_PULL:
            begin
                // Reads issue back to back; rd_q is registered, so data lands in the next cycle.
                ram_re = 1'b1; ram_addr = AW'(sp_reg + 8'd1);
                sp_next = sp_reg + 8'd1;
                cnt_next = cnt_reg - 2'd1;
                if (cnt_reg != 2'd2 || op_reg != c8x_pkg::OP_RTI)
                    pull0_next = rd_q;
                if (cnt_reg == 2'd1 && op_reg == c8x_pkg::OP_RTI)
                    p_next = (rd_q & 8'hCF) | 8'h20;
            end
            c8x_pkg::ST_PULL_WAIT:
            begin
                mw_next = 1'b0; wd_next = 8'h00;
                case (op_reg)
                    c8x_pkg::OP_PLA:
                    begin
                        a_next = rd_q;
                        p_next[c8x_pkg::FL_Z] = (rd_q == 8'h00);
                        p_next[c8x_pkg::FL_N] = rd_q[7];
                    end
                    c8x_pkg::OP_PLP: p_next = (rd_q & 8'hCF) | 8'h20;
                    c8x_pkg::OP_RTI: npc_next = {rd_q, pull0_reg};
                    default:
                    begin
                        addr16 = {rd_q, pull0_reg};
                        npc_next = addr16 + 16'd1;
                    end
                endcase
            end
            c8x_pkg::ST_OUT:
                if (out_free)
                    ov_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
            ram[ram_addr] <= ram_wd;
        if (ram_re)
            rd_q <= ram[ram_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c8x_pkg::ST_CLEAR;
            a_reg <= 8'h00; x_reg <= 8'h00; y_reg <= 8'h00;
            sp_reg <= c8x_pkg::SP_RESET; p_reg <= c8x_pkg::STATUS_RESET;
            halt_reg <= 1'b0; ov_reg <= 1'b0;
            clr_reg <= '0; cnt_reg <= 2'd0;
            op_reg <= c8x_pkg::OP_NOP;
        end
        else
        begin
            state_reg <= state_next;
            a_reg <= a_next; x_reg <= x_next; y_reg <= y_next;
            sp_reg <= sp_next; p_reg <= p_next;
            halt_reg <= halt_next; ov_reg <= ov_next;
            clr_reg <= clr_next; cnt_reg <= cnt_next;
            op_reg <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg <= pc_next;
        pull0_reg <= pull0_next;
        npc_reg <= npc_next; mw_reg <= mw_next; wd_reg <= wd_next;
    end

    assign out_valid = ov_reg;
    assign next_pc = npc_reg;
    assign mem_write = mw_reg;
    assign write_data = wd_reg;
    assign acc_out = a_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign sp_out = sp_reg;
    assign status_out = p_reg;
    assign halted = halt_reg;

    `ASSERT_IMPLY(a_no_take_busy, clk, rst_n, state_reg != c8x_pkg::ST_RUN, in_stall,
        "word accepted while sequencer busy")
    `ASSERT_IMPLY(a_status_bits, clk, rst_n, 1'b1, p_reg[5] && !p_reg[4],
        "status bit 5 or bit 4 wrong")
    `ASSERT_NEXT(a_halt_sticky, clk, rst_n, halt_reg, halt_reg, "halt cleared")
    `ASSERT_IMPLY(a_wd_zero, clk, rst_n, out_valid && !mem_write, write_data == 8'h00,
        "write data not zero without write")

endmodule
